// ===== rtl/core/btt_pkg.sv =====
// ----------------------------------------------------------------------------
// btt_pkg
// Widths, constants and reset values shared by the beep tone timer.
// ----------------------------------------------------------------------------
`default_nettype none

package btt_pkg;

    // Field widths
    localparam int FREQ_W     = 16;
    localparam int DUR_W      = 16;
    localparam int VOL_W      = 4;
    localparam int STEP_W     = 7;
    localparam int PERIOD_W   = 21;
    localparam int DUTY_W     = 20;
    localparam int DEAD_W     = 16;
    localparam int CFG_IDX_W  = 3;

    // Dividend of the on-time division: period times step
    localparam int NUM_W      = PERIOD_W + STEP_W;

    // PWM reference clock and on-time divisor
    localparam logic [PERIOD_W-1:0] PWM_CLOCK_HZ = PERIOD_W'(2000000);
    localparam logic [FREQ_W-1:0]   STEP_DIVISOR = FREQ_W'(200);

    // Number of volume levels
    localparam int VOLUME_LEVELS_DEF = 5;
    localparam int VOLUME_LEVELS_MAX = 8;

    // Operation codes
    localparam logic OP_BEEP = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Reset value of each volume step register
    function automatic logic [STEP_W-1:0] step_reset(input int idx);
        logic [STEP_W-1:0] val;
        case (idx)
            0:       val = STEP_W'(3);
            1:       val = STEP_W'(9);
            2:       val = STEP_W'(20);
            3:       val = STEP_W'(40);
            default: val = STEP_W'(80);
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/beep_tone_timer.sv =====
// ----------------------------------------------------------------------------
// beep_tone_timer
// Beep request and millisecond tick handler for a PWM tone generator.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A tick, a silent or busy beep and a
// beep with zero frequency go from acceptance straight to the commit state,
// and the block is ready again in the cycle the result is presented. A beep
// that starts a tone runs a bit-serial restoring divider for 2000000 /
// frequency, a shift-add multiply of the period by the volume step and the
// same divider again for the division by 200, then commits. The shared
// divider yields one quotient bit per cycle. A finished result is held in
// the output register while the next transaction is accepted; commit waits
// only for that register.
// ----------------------------------------------------------------------------
`default_nettype none

module beep_tone_timer #(
    parameter int VOLUME_LEVELS = btt_pkg::VOLUME_LEVELS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration port
    input  wire logic                            i_cfg_we,
    input  wire logic [btt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [btt_pkg::STEP_W-1:0]      i_cfg_data,
    // input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_op,
    input  wire logic [btt_pkg::FREQ_W-1:0]      i_frequency,
    input  wire logic [btt_pkg::DUR_W-1:0]       i_duration_ms,
    input  wire logic [btt_pkg::VOL_W-1:0]       i_volume,
    // output channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_tone_on,
    output logic [btt_pkg::PERIOD_W-1:0]         o_pwm_period,
    output logic [btt_pkg::DUTY_W-1:0]           o_pwm_duty,
    output logic [btt_pkg::DEAD_W-1:0]           o_dead_time,
    output logic                                 o_busy_res,
    output logic                                 o_started,
    output logic                                 o_bad_frequency
);

    import btt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_COMMIT
    } t_state;

    localparam int CNT_W = $clog2(NUM_W + 1);

    // volume step registers
    logic [STEP_W-1:0]   r_steps [VOLUME_LEVELS];

    // control
    t_state              r_state;
    logic                r_phase;      // 0: period division, 1: on-time division
    logic [CNT_W-1:0]    r_cnt;

    // latched transaction
    logic                r_op;
    logic                r_start;
    logic                r_bad;
    logic [DUR_W-1:0]    r_dur;
    logic [STEP_W-1:0]   r_step;

    // datapath
    logic [NUM_W-1:0]    r_num;        // dividend shifter and product accumulator
    logic [NUM_W-1:0]    r_mcand;
    logic [STEP_W-1:0]   r_mplier;
    logic [FREQ_W-1:0]   r_rem;
    logic [FREQ_W-1:0]   r_den;
    logic [PERIOD_W-1:0] r_quo;
    logic [PERIOD_W-1:0] r_new_period;
    logic [DEAD_W-1:0]   r_new_dead;

    // architectural state
    logic [DUR_W-1:0]    r_ticks;
    logic                r_tone;
    logic [PERIOD_W-1:0] r_period_reg;
    logic [DEAD_W-1:0]   r_dead_reg;

    // output register
    logic                r_out_valid;
    logic                r_out_tone;
    logic [PERIOD_W-1:0] r_out_period;
    logic [DEAD_W-1:0]   r_out_dead;
    logic                r_out_busy;
    logic                r_out_started;
    logic                r_out_bad;

    // combinational
    logic                in_acc;
    logic                commit;
    logic                beep_live;
    logic [VOL_W-1:0]    level;
    logic [STEP_W-1:0]   sel_step;
    logic [FREQ_W:0]     rem_sh;
    logic                q_bit;
    logic [FREQ_W:0]     rem_diff;
    logic [FREQ_W-1:0]   n_rem;
    logic [PERIOD_W-1:0] n_quo;
    logic [DUR_W-1:0]    n_ticks;
    logic                n_tone;
    logic [PERIOD_W-1:0] n_period;
    logic [DEAD_W-1:0]   n_dead;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign commit     = (r_state == S_COMMIT) && (!r_out_valid || i_out_ready);

    // Clamp the volume and pick its step register
    always_comb begin
        level = (i_volume > VOL_W'(VOLUME_LEVELS)) ? VOL_W'(VOLUME_LEVELS) : i_volume;
        sel_step = '0;
        for (int i = 0; i < VOLUME_LEVELS; i++) begin
            if (level == VOL_W'(i + 1)) begin
                sel_step = r_steps[i];
            end
        end
    end

    assign beep_live = (i_op == OP_BEEP) && (i_volume != '0) && (r_ticks == '0);

    // One restoring division step
    always_comb begin
        rem_sh   = {r_rem, r_num[NUM_W-1]};
        rem_diff = rem_sh - {1'b0, r_den};
        q_bit    = (rem_sh >= {1'b0, r_den});
        n_rem    = q_bit ? rem_diff[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
        n_quo    = {r_quo[PERIOD_W-2:0], q_bit};
    end

    // Next architectural state at commit
    always_comb begin
        n_ticks  = r_ticks;
        n_tone   = r_tone;
        n_period = r_period_reg;
        n_dead   = r_dead_reg;
        if (r_op == OP_TICK) begin
            if (r_ticks != '0) begin
                n_ticks = r_ticks - DUR_W'(1);
                if (r_ticks == DUR_W'(1)) begin
                    n_tone = 1'b0;
                end
            end
        end else if (r_start) begin
            n_ticks  = r_dur;
            n_tone   = 1'b1;
            n_period = r_new_period;
            n_dead   = r_new_dead;
        end
    end

    // Hold the volume step registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOLUME_LEVELS; i++) begin
                r_steps[i] <= step_reset(i);
            end
        end else begin
            for (int i = 0; i < VOLUME_LEVELS; i++) begin
                if (i_cfg_we && (i_cfg_idx == CFG_IDX_W'(i))) begin
                    r_steps[i] <= i_cfg_data;
                end
            end
        end
    end

    // Sequencer, datapath, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= 1'b0;
            r_cnt        <= '0;
            r_ticks      <= '0;
            r_tone       <= 1'b0;
            r_period_reg <= '0;
            r_dead_reg   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // drop the result once taken
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op    <= i_op;
                        r_dur   <= i_duration_ms;
                        r_step  <= sel_step;
                        r_start <= beep_live && (i_frequency != '0);
                        r_bad   <= beep_live && (i_frequency == '0);
                        if (beep_live && (i_frequency != '0)) begin
                            // load the divider for the period
                            r_num   <= {PWM_CLOCK_HZ, STEP_W'(0)};
                            r_rem   <= '0;
                            r_quo   <= '0;
                            r_den   <= i_frequency;
                            r_cnt   <= CNT_W'(PERIOD_W);
                            r_phase <= 1'b0;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_COMMIT;
                        end
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(1)) begin
                        if (!r_phase) begin
                            r_new_period <= n_quo;
                            r_num        <= '0;
                            r_mcand      <= NUM_W'(n_quo);
                            r_mplier     <= r_step;
                            r_cnt        <= CNT_W'(STEP_W);
                            r_state      <= S_MUL;
                        end else begin
                            r_new_dead <= r_new_period[DEAD_W:1] - n_quo[DEAD_W-1:0];
                            r_state    <= S_COMMIT;
                        end
                    end else begin
                        // advance one quotient bit
                        r_num <= {r_num[NUM_W-2:0], 1'b0};
                        r_rem <= n_rem;
                        r_quo <= n_quo;
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_MUL: begin
                    // shift-add one multiplier bit
                    if (r_mplier[0]) begin
                        r_num <= r_num + r_mcand;
                    end
                    r_mcand  <= {r_mcand[NUM_W-2:0], 1'b0};
                    r_mplier <= r_mplier >> 1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_den   <= STEP_DIVISOR;
                        r_cnt   <= CNT_W'(NUM_W);
                        r_phase <= 1'b1;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_COMMIT: begin
                    if (commit) begin
                        r_ticks       <= n_ticks;
                        r_tone        <= n_tone;
                        r_period_reg  <= n_period;
                        r_dead_reg    <= n_dead;
                        r_out_tone    <= n_tone;
                        r_out_period  <= n_period;
                        r_out_dead    <= n_dead;
                        r_out_busy    <= (n_ticks != '0);
                        r_out_started <= r_start;
                        r_out_bad     <= r_bad;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tone_on       = r_out_tone;
    assign o_pwm_period    = r_out_period;
    assign o_pwm_duty      = r_out_period[PERIOD_W-1:1];
    assign o_dead_time     = r_out_dead;
    assign o_busy_res      = r_out_busy;
    assign o_started       = r_out_started;
    assign o_bad_frequency = r_out_bad;

endmodule

`default_nettype wire

// ===== tb/tb_beep_tone_timer.sv =====
// ----------------------------------------------------------------------------
// tb_beep_tone_timer
// Self-checking bench for the beep tone timer: beep requests and millisecond
// ticks go in through a valid/ready channel, and every result is compared
// field by field against a cycle-free predictor of the countdown, the PWM
// period and the dead time, over several volume step settings.
// ----------------------------------------------------------------------------

// One result transaction of the block
typedef struct packed {
    logic                              tone_on;
    logic [btt_pkg::PERIOD_W-1:0]      pwm_period;
    logic [btt_pkg::DUTY_W-1:0]        pwm_duty;
    logic [btt_pkg::DEAD_W-1:0]        dead_time;
    logic                              busy;
    logic                              started;
    logic                              bad_frequency;
} t_tone_result;

// Predicts the tone state and checks results in order
class tone_scoreboard;
    localparam int STEP_REGS  = 5;
    localparam int VOL_LEVELS = btt_pkg::VOLUME_LEVELS_DEF;

    logic [btt_pkg::STEP_W-1:0]   vol_step [STEP_REGS];
    logic [btt_pkg::DUR_W-1:0]    countdown;
    logic                         tone_enabled;
    logic [btt_pkg::PERIOD_W-1:0] period_q;
    logic [btt_pkg::DEAD_W-1:0]   dead_q;
    t_tone_result                 expected_q [$];
    int                           errors;

    function new();
        for (int i = 0; i < STEP_REGS; i++) vol_step[i] = btt_pkg::step_reset(i);
        countdown    = '0;
        tone_enabled = 1'b0;
        period_q     = '0;
        dead_q       = '0;
        errors       = 0;
    endfunction

    function void set_step(int idx, logic [btt_pkg::STEP_W-1:0] val);
        if (idx < STEP_REGS) vol_step[idx] = val;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Advance the predicted state by one accepted request and queue its result
    function void note_request(logic op, logic [btt_pkg::FREQ_W-1:0] freq,
                               logic [btt_pkg::DUR_W-1:0] dur,
                               logic [btt_pkg::VOL_W-1:0] vol);
        bit [31:0]    period;
        bit [31:0]    on_time;
        bit [31:0]    dead;
        int           level;
        t_tone_result r;
        r = '0;
        if (op == btt_pkg::OP_BEEP) begin
            if (vol != 0 && countdown == 0) begin
                level = (vol > VOL_LEVELS) ? VOL_LEVELS : int'(vol);
                if (freq == 0) begin
                    r.bad_frequency = 1'b1;
                end else begin
                    period  = 32'(btt_pkg::PWM_CLOCK_HZ) / 32'(freq);
                    on_time = (period * 32'(vol_step[level-1]))
                              / 32'(btt_pkg::STEP_DIVISOR);
                    dead    = (period / 2) - on_time;
                    period_q     = period[btt_pkg::PERIOD_W-1:0];
                    dead_q       = dead[btt_pkg::DEAD_W-1:0];
                    tone_enabled = 1'b1;
                    countdown    = dur;
                    r.started    = 1'b1;
                end
            end
        end else if (countdown != 0) begin
            countdown = countdown - btt_pkg::DUR_W'(1);
            if (countdown == 0) tone_enabled = 1'b0;
        end
        r.tone_on    = tone_enabled;
        r.pwm_period = period_q;
        r.pwm_duty   = period_q[btt_pkg::PERIOD_W-1:1];
        r.dead_time  = dead_q;
        r.busy       = (countdown != 0);
        expected_q.push_back(r);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(t_tone_result got);
        t_tone_result want;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("result with no request outstanding: tone_on=%0d period=%0d",
                         got.tone_on, got.pwm_period);
            return;
        end
        want = expected_q.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10)
                $display({"mismatch: tone_on %0d/%0d period %0d/%0d duty %0d/%0d ",
                          "dead %0d/%0d busy %0d/%0d started %0d/%0d bad_freq %0d/%0d ",
                          "(expected/actual)"},
                         want.tone_on, got.tone_on, want.pwm_period, got.pwm_period,
                         want.pwm_duty, got.pwm_duty, want.dead_time, got.dead_time,
                         want.busy, got.busy, want.started, got.started,
                         want.bad_frequency, got.bad_frequency);
        end
    endfunction
endclass

module tb_beep_tone_timer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEP_REGS      = 5;
    localparam int ITEMS_PER_PASS = 255;

    logic                              i_clk;
    logic                              i_rst_n      = 1'b0;
    logic                              cfg_we       = 1'b0;
    logic [btt_pkg::CFG_IDX_W-1:0]     cfg_idx      = '0;
    logic [btt_pkg::STEP_W-1:0]        cfg_data     = '0;
    logic                              in_valid     = 1'b0;
    logic                              in_ready;
    logic                              op           = btt_pkg::OP_TICK;
    logic [btt_pkg::FREQ_W-1:0]        frequency    = '0;
    logic [btt_pkg::DUR_W-1:0]         duration_ms  = '0;
    logic [btt_pkg::VOL_W-1:0]         volume       = '0;
    logic                              out_valid;
    logic                              out_ready    = 1'b0;
    t_tone_result                      res;

    tone_scoreboard                    sb;
    bit                                idle_on       = 1'b1;
    bit                                long_hold_req = 1'b0;
    int                                items_sent    = 0;
    logic [btt_pkg::DUR_W-1:0]         countdown_shadow = '0;

    beep_tone_timer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_op            (op),
        .i_frequency     (frequency),
        .i_duration_ms   (duration_ms),
        .i_volume        (volume),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_tone_on       (res.tone_on),
        .o_pwm_period    (res.pwm_period),
        .o_pwm_duty      (res.pwm_duty),
        .o_dead_time     (res.dead_time),
        .o_busy_res      (res.busy),
        .o_started       (res.started),
        .o_bad_frequency (res.bad_frequency)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous overall limit
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // Note accepted requests before results in the same cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && in_ready) sb.note_request(op, frequency, duration_ms, volume);
            if (out_valid && out_ready) sb.check_result(res);
        end
    end

    // Drive the result ready with random stalls and one long hold-off
    always begin : result_sink
        int n;
        if (long_hold_req) begin
            out_ready     <= 1'b0;
            n             = 400;
            long_hold_req = 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            out_ready <= 1'b0;
            n         = $urandom_range(1, 8);
        end else begin
            out_ready <= 1'b1;
            n         = $urandom_range(1, 12);
        end
        repeat (n) @(posedge i_clk);
    end

    // Offer one request and hold it until accepted
    task automatic send_item(logic o, logic [btt_pkg::FREQ_W-1:0] f,
                             logic [btt_pkg::DUR_W-1:0] d, logic [btt_pkg::VOL_W-1:0] v);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        frequency   <= f;
        duration_ms <= d;
        volume      <= v;
        do @(posedge i_clk); while (!in_ready);
        items_sent++;
        // keep a countdown copy to steer the stimulus
        if (o == btt_pkg::OP_BEEP) begin
            if (v != 0 && countdown_shadow == 0 && f != 0) countdown_shadow = d;
        end else if (countdown_shadow != 0) begin
            countdown_shadow = countdown_shadow - btt_pkg::DUR_W'(1);
        end
    endtask

    task automatic send_tick();
        send_item(btt_pkg::OP_TICK, 16'($urandom), 16'($urandom), 4'($urandom));
    endtask

    // Drop valid and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write all volume steps back to back
    task automatic write_steps(logic [btt_pkg::STEP_W-1:0] vals [STEP_REGS]);
        for (int i = 0; i < STEP_REGS; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= btt_pkg::CFG_IDX_W'(i);
            cfg_data <= vals[i];
            @(posedge i_clk);
            sb.set_step(i, vals[i]);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [btt_pkg::FREQ_W-1:0] pick_freq();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return btt_pkg::FREQ_W'($urandom_range(1, 10));
            2:       return btt_pkg::FREQ_W'($urandom_range(65000, 65535));
            default: return btt_pkg::FREQ_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // A beep followed by ticks, with busy beeps and noise mixed in
    task automatic random_sequence();
        logic [btt_pkg::DUR_W-1:0] d;
        logic [btt_pkg::VOL_W-1:0] v;
        int                        n;
        case ($urandom_range(0, 9))
            0: send_item(btt_pkg::OP_BEEP, 16'($urandom), 16'($urandom), '0);
            1: send_item(btt_pkg::OP_BEEP, '0, 16'($urandom), 4'($urandom));
            default: begin
                v = ($urandom_range(0, 9) == 0) ? '0 : 4'($urandom_range(1, 15));
                d = ($urandom_range(0, 3) == 0) ? '0 : 16'($urandom_range(1, 12));
                send_item(btt_pkg::OP_BEEP, pick_freq(), d, v);
                n = $urandom_range(0, int'(d) + 3);
                repeat (n) begin
                    if (countdown_shadow != 0 && $urandom_range(0, 5) == 0)
                        send_item(btt_pkg::OP_BEEP, 16'($urandom), 16'($urandom),
                                  4'($urandom));
                    send_tick();
                end
            end
        endcase
    endtask

    // Stimulus
    initial begin
        logic [btt_pkg::STEP_W-1:0] steps [STEP_REGS];
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle tick, silent, zero frequency, busy, clamp, zero duration
        send_tick();
        send_item(btt_pkg::OP_BEEP, 16'd1000, 16'd5, 4'd0);
        send_item(btt_pkg::OP_BEEP, 16'd0, 16'd10, 4'd3);
        send_item(btt_pkg::OP_BEEP, 16'd1, 16'd3, 4'd1);
        send_item(btt_pkg::OP_BEEP, 16'd440, 16'd7, 4'd5);
        send_item(btt_pkg::OP_BEEP, 16'd0, 16'd7, 4'd2);
        repeat (4) send_tick();
        send_item(btt_pkg::OP_BEEP, 16'hFFFF, 16'd2, 4'd15);
        repeat (2) send_tick();
        send_item(btt_pkg::OP_BEEP, 16'd2000, 16'd0, 4'd2);
        send_tick();
        send_item(btt_pkg::OP_BEEP, 16'd3, 16'd1, 4'd4);
        send_tick();
        send_item(btt_pkg::OP_BEEP, 16'd7, 16'd1, 4'd5);
        send_tick();
        send_item(btt_pkg::OP_BEEP, 16'd1, 16'd1, 4'd3);
        send_tick();
        send_item(btt_pkg::OP_BEEP, 16'hFFFF, 16'hFFFF, 4'd0);
        send_item(btt_pkg::OP_BEEP, 16'h8000, 16'd1, 4'd8);
        send_tick();
        drain();

        // random passes over several step settings, the last without idling
        for (int pass = 0; pass < 5; pass++) begin
            for (int i = 0; i < STEP_REGS; i++) begin
                case (pass)
                    0:       steps[i] = btt_pkg::step_reset(i);
                    1:       steps[i] = '0;
                    2:       steps[i] = btt_pkg::STEP_W'(100);
                    3:       steps[i] = '1;
                    default: steps[i] = btt_pkg::STEP_W'($urandom_range(0, 127));
                endcase
            end
            if (pass > 0) write_steps(steps);
            if (pass == 1) long_hold_req = 1'b1;
            if (pass == 4) idle_on = 1'b0;
            begin : pass_items
                int target;
                target = items_sent + ITEMS_PER_PASS;
                while (items_sent < target) random_sequence();
            end
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
